[design/pct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the preload confidence table
// Transaction payloads, the lookup token that walks the cell chain, the
// commit broadcast and the confidence threshold functions.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int TAG_W   = 64;
  localparam int INDEX_W = 32;
  localparam int COUNT_W = 4;
  localparam int LEVEL_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 2'd3;
  localparam logic [4:0]         DIST_STEP    = 5'd5;
  localparam logic [COUNT_W-1:0] PROMOTE_STEP = 4'd3;

  typedef struct packed {
    logic [TAG_W-1:0]   block_tag;
    logic [INDEX_W-1:0] access_index;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] preload_level;
    logic               table_hit;
  } out_t;

  // lookup token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [LEVEL_W-1:0] level;
    in_t                query;
  } token_t;

  // end-of-walk update sent to every cell at once
  typedef struct packed {
    logic valid;
    logic found;
    in_t  query;
  } commit_t;

  // largest index distance that still counts as a hit: (level+1)*5
  function automatic logic [4:0] dist_limit(input logic [LEVEL_W-1:0] lvl);
    logic [4:0] lim;
    begin
      lim = DIST_STEP * (5'(lvl) + 5'd1);
      return lim;
    end
  endfunction

  // hit count at which the level steps up: (level+1)*3
  function automatic logic [COUNT_W-1:0] promote_limit(input logic [LEVEL_W-1:0] lvl);
    logic [COUNT_W-1:0] lim;
    begin
      lim = PROMOTE_STEP * (COUNT_W'(lvl) + 4'd1);
      return lim;
    end
  endfunction

endpackage

[design/preload_confidence_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preload_confidence_table_unit: fully associative preload confidence table
// Tracks access streams by tag with LRU replacement and returns a 0..3
// confidence level and a hit flag for each lookup.
// ----------------------------------------------------------------------------
// A lookup is taken when start is high and busy is low. The lookup token
// walks the row of TABLE_ENTRIES cells, one cell per cycle, then the table
// commits the recency update as the token leaves the last cell; the result
// strobes on out_valid for a single cycle, and busy drops in that same
// cycle, so no new lookup is taken while one is still walking the row. The
// receiver cannot stall the result: it must take out_data whenever out_valid
// is high.
module preload_confidence_table_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pct_pkg::in_t  in_data,
  output logic          out_valid,
  output pct_pkg::out_t out_data
);
  import pct_pkg::*;

  localparam int RANK_W = $clog2(TABLE_ENTRIES);

  token_t            tok  [TABLE_ENTRIES+1];
  logic [RANK_W-1:0] rank [TABLE_ENTRIES+1];

  commit_t           cmt;
  logic [RANK_W-1:0] cmt_rank;

  logic busy_r,      busy_nxt;
  logic out_valid_r;
  out_t out_data_r;
  logic accept;

  assign accept = start && !busy_r;

  always_comb begin
    tok[0].valid = accept;
    tok[0].found = 1'b0;
    tok[0].level = '0;
    tok[0].query = in_data;
    rank[0]      = '0;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pct_cell #(
      .ENTRIES (TABLE_ENTRIES),
      .INDEX   (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok[g]),
      .rank_in  (rank[g]),
      .tok_out  (tok[g+1]),
      .rank_out (rank[g+1]),
      .cmt      (cmt),
      .cmt_rank (cmt_rank)
    );
  end

  // on a miss the victim is the entry holding the last rank
  always_comb begin
    cmt.valid = tok[TABLE_ENTRIES].valid;
    cmt.found = tok[TABLE_ENTRIES].found;
    cmt.query = tok[TABLE_ENTRIES].query;
    cmt_rank  = tok[TABLE_ENTRIES].found ? rank[TABLE_ENTRIES]
                                         : RANK_W'(TABLE_ENTRIES - 1);
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (cmt.valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= cmt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmt.valid) begin
      out_data_r.preload_level <= tok[TABLE_ENTRIES].level;
      out_data_r.table_hit     <= tok[TABLE_ENTRIES].found;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/pct_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_cell: one table entry of the preload confidence table
// Holds tag, base index, hit count, level and recency rank of one entry.
// Checks the passing lookup token, updates its counters on a first match and
// hands the token on to the next cell; applies the commit broadcast.
// ----------------------------------------------------------------------------
module pct_cell #(
  parameter int ENTRIES = 16,
  parameter int INDEX   = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pct_pkg::token_t              tok_in,
  input  logic [$clog2(ENTRIES)-1:0]   rank_in,
  output pct_pkg::token_t              tok_out,
  output logic [$clog2(ENTRIES)-1:0]   rank_out,
  input  pct_pkg::commit_t             cmt,
  input  logic [$clog2(ENTRIES)-1:0]   cmt_rank
);
  import pct_pkg::*;

  localparam int RANK_W = $clog2(ENTRIES);

  logic [TAG_W-1:0]   tag_r;
  logic [INDEX_W-1:0] base_r;
  logic [COUNT_W-1:0] cnt_r,  cnt_nxt;
  logic [LEVEL_W-1:0] lvl_r,  lvl_nxt;
  logic [RANK_W-1:0]  rank_r;
  token_t             tok_r,  tok_nxt;
  logic [RANK_W-1:0]  tok_rank_r, tok_rank_nxt;

  logic               match;
  logic [INDEX_W-1:0] idx_gap;
  logic               near;

  assign match   = tok_in.valid && !tok_in.found && (tag_r == tok_in.query.block_tag);
  assign idx_gap = tok_in.query.access_index - base_r;
  assign near    = idx_gap <= INDEX_W'(dist_limit(lvl_r));

  always_comb begin
    cnt_nxt = cnt_r;
    if (near && (cnt_r != COUNT_MAX)) begin
      cnt_nxt = cnt_r + 4'd1;
    end
    lvl_nxt = lvl_r;
    if ((cnt_nxt >= promote_limit(lvl_r)) && (lvl_r != LEVEL_MAX)) begin
      lvl_nxt = lvl_r + 2'd1;
    end
  end

  always_comb begin
    tok_nxt      = tok_in;
    tok_rank_nxt = rank_in;
    if (match) begin
      tok_nxt.found = 1'b1;
      tok_nxt.level = lvl_nxt;
      tok_rank_nxt  = rank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
    tok_rank_r <= tok_rank_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= '0;
      base_r <= '0;
      cnt_r  <= '0;
      lvl_r  <= '0;
      rank_r <= RANK_W'(INDEX);
    end else begin
      if (match) begin
        cnt_r <= cnt_nxt;
        lvl_r <= lvl_nxt;
      end
      if (cmt.valid) begin
        if (rank_r < cmt_rank) begin
          rank_r <= rank_r + 1'b1;
        end else if (rank_r == cmt_rank) begin
          rank_r <= '0;
          // miss: the least recent entry takes over the new stream
          if (!cmt.found) begin
            tag_r  <= cmt.query.block_tag;
            base_r <= cmt.query.access_index;
            cnt_r  <= '0;
            lvl_r  <= '0;
          end
        end
      end
    end
  end

  assign tok_out  = tok_r;
  assign rank_out = tok_rank_r;

endmodule

[design/pct_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_checker: port-level checks for the preload confidence table
// Watches the command handshake and the result strobe of the top level.
// ----------------------------------------------------------------------------
module pct_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input pct_pkg::out_t out_data
);
  import pct_pkg::*;

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // a result is a single-cycle strobe
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // busy only drops together with a result
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // a miss always reports level zero, as a replaced entry starts there
  a_miss_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.table_hit) |-> (out_data.preload_level == '0))
    else $error("miss reported a nonzero level");

endmodule

bind preload_confidence_table_unit pct_checker u_pct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
